// ----- design/oli_pkg.sv -----
// Shared constants and result codes for the ordered list insert/delete engine.
// No dependencies; the top level and its checker use it by scoped names.
`default_nettype none

package oli_pkg;

  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;

  // field widths fixed by the interface
  localparam int IN_VALUE_W = 32;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 6;

  // internal widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((LEN_W + 1) > POS_W) ? (LEN_W + 1) : POS_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADPOS  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } command_t;

endpackage

`default_nettype wire

// ----- design/ordered_list_insert_delete.sv -----
// Ordered list engine: insert at a 1-based position, delete first match.
// Holds the list in a simple dual-port memory walked by a small sequencer.
// Depends on oli_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, command, value,       | to block
//          | position                                  |
//  out     | out_valid, out_ready, status, element_count,
//          | hit_position                              | from block
//
// From the accepting edge to out_valid: an insert shifts the entries from the
// tail down to its position, then writes (an append writes at once); a delete
// walks the whole list whether it hits or misses; a rejected item finishes at
// once. The memory serves one read and one write per cycle.
// rst is synchronous and empties the list; the memory itself is not cleared.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds the sequencer at its last step, not the idle state.
`default_nettype none

module ordered_list_insert_delete (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           in_valid,
  output logic                                 in_ready,
  input  wire  logic [0:0]                     command,
  input  wire  logic signed [oli_pkg::IN_VALUE_W-1:0] value,
  input  wire  logic [oli_pkg::POS_W-1:0]      position,
  output logic                                 out_valid,
  input  wire  logic                           out_ready,
  output logic [oli_pkg::STATUS_W-1:0]         status,
  output logic [oli_pkg::COUNT_W-1:0]          element_count,
  output logic [oli_pkg::POS_W-1:0]            hit_position
);

  localparam int IDX_W = oli_pkg::IDX_W;
  localparam int LEN_W = oli_pkg::LEN_W;
  localparam int CMP_W = oli_pkg::CMP_W;
  localparam int VB    = oli_pkg::VALUE_BITS;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_INS_TAIL  = 7'b0000100,
    S_INS_WRITE = 7'b0001000,
    S_DEL_SCAN  = 7'b0010000,
    S_DEL_SHIFT = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t              state;
  logic [LEN_W-1:0]    len;
  logic [VB-1:0]       key;
  logic [IDX_W-1:0]    ins_addr;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    wa;
  logic [IDX_W-1:0]    cmp_addr;
  logic                pv;
  oli_pkg::status_t    res_status;
  logic [oli_pkg::POS_W-1:0] res_hit;

  // list memory
  logic [VB-1:0]       mem [oli_pkg::CAPACITY];
  logic [VB-1:0]       rdata;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [VB-1:0]       mem_wd;
  logic [IDX_W-1:0]    mem_ra;

  logic                in_fire;
  logic                out_free;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    len_plus1;
  logic [LEN_W-1:0]    len_m1;
  logic [LEN_W-1:0]    len_m2;
  logic                match;
  logic [VB-1:0]       value_key;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign pos_ext   = CMP_W'(position);
  assign len_plus1 = CMP_W'(len) + CMP_W'(1);
  assign len_m1    = len - LEN_W'(1);
  assign len_m2    = len - LEN_W'(2);
  assign match     = pv && (rdata == key);
  assign value_key = VB'(value);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa;
    mem_wd = rdata;
    mem_ra = idx;
    case (state)
      S_INS_SHIFT: mem_we = pv;
      S_INS_TAIL:  mem_we = 1'b1;
      S_INS_WRITE: begin
        mem_we = 1'b1;
        mem_wa = ins_addr;
        mem_wd = key;
      end
      S_DEL_SHIFT: begin
        mem_we = 1'b1;
        mem_ra = wa + IDX_W'(2);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      // the finish step reloads the result register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            key      <= value_key;
            ins_addr <= IDX_W'(position - oli_pkg::POS_W'(1));
            pv       <= 1'b0;
            res_hit  <= '0;
            if (command == oli_pkg::CMD_INSERT) begin
              if (position == '0 || pos_ext > len_plus1) begin
                res_status <= oli_pkg::ST_BADPOS;
                state      <= S_FINISH;
              end else if (len == LEN_W'(oli_pkg::CAPACITY)) begin
                res_status <= oli_pkg::ST_FULL;
                state      <= S_FINISH;
              end else if (pos_ext == len_plus1) begin
                // append: nothing to move
                state <= S_INS_WRITE;
              end else begin
                idx   <= IDX_W'(len_m1);
                state <= S_INS_SHIFT;
              end
            end else begin
              if (len == '0) begin
                res_status <= oli_pkg::ST_EMPTY;
                state      <= S_FINISH;
              end else begin
                idx   <= '0;
                state <= S_DEL_SCAN;
              end
            end
          end
        end
        S_INS_SHIFT: begin
          // read idx, write previous read one slot back
          pv <= 1'b1;
          wa <= idx + IDX_W'(1);
          if (idx == ins_addr) begin
            state <= S_INS_TAIL;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_INS_TAIL: begin
          state <= S_INS_WRITE;
        end
        S_INS_WRITE: begin
          len        <= len + LEN_W'(1);
          res_status <= oli_pkg::ST_OK;
          res_hit    <= oli_pkg::POS_W'(ins_addr) + oli_pkg::POS_W'(1);
          state      <= S_FINISH;
        end
        S_DEL_SCAN: begin
          if (match) begin
            res_status <= oli_pkg::ST_OK;
            res_hit    <= oli_pkg::POS_W'(cmp_addr) + oli_pkg::POS_W'(1);
            wa         <= cmp_addr;
            if (LEN_W'(cmp_addr) == len_m1) begin
              len   <= len_m1;
              state <= S_FINISH;
            end else begin
              state <= S_DEL_SHIFT;
            end
          end else if (pv && LEN_W'(cmp_addr) == len_m1) begin
            res_status <= oli_pkg::ST_MISSING;
            state      <= S_FINISH;
          end else begin
            pv       <= 1'b1;
            cmp_addr <= idx;
            idx      <= idx + IDX_W'(1);
          end
        end
        S_DEL_SHIFT: begin
          // close the gap: entry wa+1 moves to wa
          wa <= wa + IDX_W'(1);
          if (LEN_W'(wa) == len_m2) begin
            len   <= len_m1;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            element_count <= oli_pkg::COUNT_W'(len);
            hit_position  <= res_hit;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/oli_checker.sv -----
// Port-level checks for ordered_list_insert_delete, attached by bind.
// Depends on oli_pkg.
`default_nettype none

module oli_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [oli_pkg::STATUS_W-1:0]   status,
  input wire logic [oli_pkg::COUNT_W-1:0]    element_count,
  input wire logic [oli_pkg::POS_W-1:0]      hit_position
);

  // a failed operation reports no position
  a_fail_no_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != oli_pkg::ST_OK) |-> (hit_position == '0))
    else $error("failed beat carries a hit position");

  // a successful operation names a position from 1 to CAPACITY
  a_ok_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == oli_pkg::ST_OK) |->
      (hit_position != '0 && hit_position <= oli_pkg::POS_W'(oli_pkg::CAPACITY)))
    else $error("ok beat without a valid hit position");

  // the count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (element_count <= oli_pkg::COUNT_W'(oli_pkg::CAPACITY)))
    else $error("element count above capacity");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(element_count) && $stable(hit_position)))
    else $error("stalled result changed");

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .element_count (element_count),
  .hit_position  (hit_position)
);

`default_nettype wire
